@@ sv/winning_set_fixed_point_core_macros.svh @@
// Assertion macros shared by the solver RTL.
`ifndef WINNING_SET_FIXED_POINT_CORE_MACROS_SVH
`define WINNING_SET_FIXED_POINT_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define WSFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wsfp_pkg.sv @@
// Shared constants, codes and control structs of the winning set solver.
`default_nettype none
package wsfp_pkg;

    localparam int WSFP_CELLS    = 4096;
    localparam int WSFP_MAX_SUCC = 8;

    localparam int IN_W  = 40;
    localparam int OUT_W = 96;

    localparam logic [1:0] ACT_LOAD_CELL = 2'd0;
    localparam logic [1:0] ACT_LOAD_SUCC = 2'd1;
    localparam logic [1:0] ACT_SOLVE     = 2'd2;

    typedef struct packed {
        logic load;
        logic solve_start;
        logic init_step;
        logic sweep_clr;
        logic cell_rd;
        logic cell_cap;
        logic edge_rd;
        logic win_rd;
        logic k_inc;
        logic good_set;
        logic good_clr;
        logic upd;
        logic sweep_inc;
        logic emit_start;
        logic emit_rd;
        logic emit_cap;
        logic ea_inc;
        logic emit_out;
    } t_cmd;

    typedef struct packed {
        logic c_last;
        logic cnt_zero;
        logic k_last;
        logic edge_bad;
        logic win_low;
        logic cont;
        logic k63;
        logic last_word;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ sv/wsfp_dp.sv @@
// Datapath: cell, successor and winning set memories, counters, output register.
`default_nettype none
module wsfp_dp
    import wsfp_pkg::*;
#(
    parameter int CELLS    = WSFP_CELLS,
    parameter int MAX_SUCC = WSFP_MAX_SUCC
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IN_W-1:0]  i_in_data,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    input  wire logic             i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_W-1:0]      o_m_tdata,
    output logic                  o_m_tlast
);
    localparam int CW    = $clog2(CELLS);
    localparam int NW    = (CELLS + 63) / 64;
    localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int AW    = 6 + WW;
    localparam int TW    = $clog2(CELLS * MAX_SUCC);
    localparam int KW    = $clog2(MAX_SUCC + 1);
    localparam int DEPTH = CELLS * MAX_SUCC;

    // input fields
    logic [1:0]  act;
    logic [11:0] cell_req;
    logic        in_spec;
    logic [3:0]  succ_cnt;
    logic [2:0]  slot;
    logic [11:0] succ;
    logic        succ_out;
    assign act      = i_in_data[1:0];
    assign cell_req = i_in_data[13:2];
    assign in_spec  = i_in_data[14];
    assign succ_cnt = i_in_data[18:15];
    assign slot     = i_in_data[21:19];
    assign succ     = i_in_data[33:22];
    assign succ_out = i_in_data[34];

    logic            r_spec_mem [CELLS];
    logic [KW-1:0]   r_cnt_mem  [CELLS];
    logic [12:0]     r_tab_mem  [DEPTH];
    logic            r_win_mem  [CELLS];

    logic            r_spec_q;
    logic [KW-1:0]   r_cnt_q;
    logic [12:0]     r_edge_q;
    logic            r_win_q;

    logic [CW-1:0]   r_c;
    logic [KW-1:0]   r_k;
    logic [KW-1:0]   r_cnt;
    logic            r_wc;
    logic            r_good;
    logic            r_changed;
    logic [12:0]     r_sweeps;
    logic [12:0]     r_count;
    logic            r_mode;
    logic            r_cp_vld;
    logic [CW-1:0]   r_cp_addr;
    logic [AW-1:0]   r_ea;
    logic            r_ein;
    logic [63:0]     r_word;

    logic            cell_ok;
    logic            slot_ok;
    logic            cnt_sat;
    logic [CW-1:0]   cell_a;
    logic [KW-1:0]   cnt_val;
    logic [TW-1:0]   ld_addr;
    logic [TW-1:0]   rd_addr;
    logic            will_change;
    logic            w_en;
    logic [CW-1:0]   w_addr;
    logic            w_data;
    logic            r_en;
    logic [CW-1:0]   r_addr;
    logic [WW-1:0]   word_no;

    assign cell_ok = {1'b0, cell_req} < 13'(CELLS);
    assign slot_ok = 7'(slot) < 7'(MAX_SUCC);
    assign cnt_sat = 7'(succ_cnt) > 7'(MAX_SUCC);
    assign cell_a  = cell_req[CW-1:0];
    assign cnt_val = cnt_sat ? KW'(MAX_SUCC) : KW'(succ_cnt);
    assign ld_addr = TW'(32'(cell_a) * MAX_SUCC + 32'(slot));
    assign rd_addr = TW'(32'(r_c) * MAX_SUCC + 32'(r_k));

    // invariance drops a winning cell, reachability adds a losing one
    assign will_change = r_mode ? (!r_wc && r_good) : (r_wc && !r_good);

    assign w_en   = r_cp_vld || (i_cmd.upd && will_change);
    assign w_addr = r_cp_vld ? r_cp_addr : r_c;
    assign w_data = r_cp_vld ? r_spec_q : r_mode;

    assign r_en   = i_cmd.cell_rd || i_cmd.win_rd || i_cmd.emit_rd;
    assign r_addr = i_cmd.win_rd  ? r_edge_q[CW-1:0] :
                    i_cmd.emit_rd ? r_ea[CW-1:0] : r_c;

    assign word_no = r_ea[AW-1:6];

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && act == ACT_LOAD_CELL && cell_ok) begin
            r_spec_mem[cell_a] <= in_spec;
            r_cnt_mem[cell_a]  <= cnt_val;
        end
        if (i_cmd.init_step) begin
            r_spec_q <= r_spec_mem[r_c];
        end
        if (i_cmd.cell_rd) begin
            r_cnt_q <= r_cnt_mem[r_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && act == ACT_LOAD_SUCC && cell_ok && slot_ok) begin
            r_tab_mem[ld_addr] <= {succ_out, succ};
        end
        if (i_cmd.edge_rd) begin
            r_edge_q <= r_tab_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_win_mem[w_addr] <= w_data;
        end
        if (r_en) begin
            r_win_q <= r_win_mem[r_addr];
        end
    end

    // counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_c       <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
            r_wc      <= 1'b0;
            r_good    <= 1'b0;
            r_changed <= 1'b0;
            r_sweeps  <= '0;
            r_count   <= '0;
            r_cp_vld  <= 1'b0;
            r_cp_addr <= '0;
            r_ea      <= '0;
            r_ein     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_cp_vld <= i_cmd.init_step;
            if (i_cmd.init_step) begin
                r_cp_addr <= r_c;
            end
            if (i_cmd.solve_start) begin
                r_c <= '0;
            end else if (i_cmd.init_step || i_cmd.upd) begin
                r_c <= o_stat.c_last ? '0 : CW'(r_c + 1'b1);
            end
            if (i_cmd.cell_rd) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= KW'(r_k + 1'b1);
            end
            if (i_cmd.cell_cap) begin
                r_cnt <= r_cnt_q;
                r_wc  <= r_win_q;
            end
            if (i_cmd.good_set) begin
                r_good <= 1'b1;
            end else if (i_cmd.good_clr) begin
                r_good <= 1'b0;
            end
            if (i_cmd.sweep_clr) begin
                r_changed <= 1'b0;
                r_count   <= '0;
            end else begin
                if (i_cmd.upd && will_change) begin
                    r_changed <= 1'b1;
                end
                if (i_cmd.cell_cap) begin
                    r_count <= r_count + 13'(r_win_q);
                end
            end
            if (i_cmd.solve_start) begin
                r_sweeps <= '0;
            end else if (i_cmd.sweep_inc) begin
                r_sweeps <= r_sweeps + 13'd1;
            end
            if (i_cmd.emit_start) begin
                r_ea <= '0;
            end else if (i_cmd.ea_inc) begin
                r_ea <= AW'(r_ea + 1'b1);
            end
            if (i_cmd.emit_rd) begin
                r_ein <= {1'b0, r_ea} < (AW+1)'(CELLS);
            end
        end
    end

    // 64 bit shifts in from the top, so cell k lands in bit k
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cap) begin
            r_word <= {r_ein && r_win_q, r_word[63:1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.emit_out) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            o_m_tdata <= {r_count, r_sweeps, r_word, 6'(word_no)};
            o_m_tlast <= o_stat.last_word;
        end
    end

    always_comb begin
        o_stat.c_last    = r_c == CW'(CELLS - 1);
        o_stat.cnt_zero  = r_cnt_q == '0;
        o_stat.k_last    = KW'(r_k + 1'b1) == r_cnt;
        o_stat.edge_bad  = r_edge_q[12] || ({1'b0, r_edge_q[11:0]} >= 13'(CELLS));
        o_stat.win_low   = !r_win_q;
        o_stat.cont      = r_changed || will_change;
        o_stat.k63       = &r_ea[5:0];
        o_stat.last_word = word_no == WW'(NW - 1);
        o_stat.out_free  = !o_m_tvalid || i_m_tready;
    end

endmodule
`default_nettype wire

@@ sv/wsfp_ctrl.sv @@
// Controller: sequences load, copy, sweep and emit phases of a solve.
`default_nettype none
module wsfp_ctrl
    import wsfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    input  wire logic  i_is_solve,
    input  wire t_stat i_stat,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_INIT  = 11'b000_0000_0010,
        S_CELL  = 11'b000_0000_0100,
        S_CNT   = 11'b000_0000_1000,
        S_EREAD = 11'b000_0001_0000,
        S_EDATA = 11'b000_0010_0000,
        S_WDATA = 11'b000_0100_0000,
        S_UPD   = 11'b000_1000_0000,
        S_ERD   = 11'b001_0000_0000,
        S_ECAP  = 11'b010_0000_0000,
        S_EOUT  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_is_solve) begin
                        o_cmd.solve_start = 1'b1;
                        n_state = S_INIT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.c_last) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                o_cmd.cell_rd = 1'b1;
                n_state = S_CNT;
            end
            S_CNT: begin
                o_cmd.cell_cap = 1'b1;
                if (i_stat.cnt_zero) begin
                    o_cmd.good_clr = 1'b1;
                    n_state = S_UPD;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = S_EDATA;
                end
            end
            S_EREAD: begin
                o_cmd.edge_rd = 1'b1;
                n_state = S_EDATA;
            end
            S_EDATA: begin
                if (i_stat.edge_bad) begin
                    o_cmd.good_clr = 1'b1;
                    n_state = S_UPD;
                end else begin
                    o_cmd.win_rd = 1'b1;
                    n_state = S_WDATA;
                end
            end
            S_WDATA: begin
                if (i_stat.win_low) begin
                    o_cmd.good_clr = 1'b1;
                    n_state = S_UPD;
                end else if (i_stat.k_last) begin
                    o_cmd.good_set = 1'b1;
                    n_state = S_UPD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_EREAD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_stat.c_last) begin
                    o_cmd.sweep_inc = 1'b1;
                    if (i_stat.cont) begin
                        o_cmd.sweep_clr = 1'b1;
                        n_state = S_CELL;
                    end else begin
                        o_cmd.emit_start = 1'b1;
                        n_state = S_ERD;
                    end
                end else begin
                    n_state = S_CELL;
                end
            end
            S_ERD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_ECAP;
            end
            S_ECAP: begin
                o_cmd.emit_cap = 1'b1;
                if (i_stat.k63) begin
                    n_state = S_EOUT;
                end else begin
                    o_cmd.ea_inc = 1'b1;
                    n_state = S_ERD;
                end
            end
            S_EOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_out = 1'b1;
                    o_cmd.ea_inc   = 1'b1;
                    n_state = i_stat.last_word ? S_IDLE : S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/winning_set_fixed_point_core.sv @@
// Winning set fixed point solver for safety and reachability games: top level.
// Input stream carries load and solve items; one item per cycle while idle.
// Action 0 loads a cell's spec bit and successor count, action 1 one successor
// slot, action 3 is dropped; loads give no output. Action 2 solves: the
// winning set is seeded from the spec bits, then swept in place until a sweep
// changes nothing. In a sweep a cell's successors are scanned in order; the
// scan stops at the first outside or losing successor. Every step waits on a
// registered memory read. Then ceil(CELLS/64) words go out, each 64-bit word
// built one bit at a time and then loaded into the output register, with
// sweep count and winning count. tready stays low from a solve until its last
// word sits in the output register. A stalled receiver holds the output
// register and the solver waits for it. spec_mode is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while idle, the
// block does not enforce this. Reset clears the controller, counters, flags
// and output valid; cell and successor memories are not cleared and must be
// loaded before a solve reads them.
`default_nettype none
`include "winning_set_fixed_point_core_macros.svh"
module winning_set_fixed_point_core
    import wsfp_pkg::*;
#(
    parameter int CELLS    = WSFP_CELLS,
    parameter int MAX_SUCC = WSFP_MAX_SUCC
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // action[1:0] cell_req[13:2] in_spec[14] successor_count[18:15]
    // slot[21:19] successor[33:22] successor_outside[34] zero[39:35]
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // word_index[5:0] winning_bits[69:6] sweep_count[82:70] winning_count[95:83]
    output logic [OUT_W-1:0]      o_m_tdata,
    output logic                  o_m_tlast
);
    t_cmd  cmd;
    t_stat stat;
    logic  is_solve;

    assign is_solve = i_s_tdata[1:0] == ACT_SOLVE;

    wsfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_is_solve (is_solve),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    wsfp_dp #(
        .CELLS    (CELLS),
        .MAX_SUCC (MAX_SUCC)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    `WSFP_ASSERT_NXT(a_solve_blocks, i_s_tvalid && o_s_tready && is_solve, !o_s_tready, "no hold")
    `WSFP_ASSERT_IMP(a_sweeps_nonzero, o_m_tvalid, o_m_tdata[82:70] != 13'd0, "zero sweep count")
    `WSFP_ASSERT_NXT(a_last_ends_run, o_m_tvalid && o_m_tlast && i_m_tready, !o_m_tvalid, "word after last")
    `WSFP_ASSERT_IMP(a_emit_not_idle, cmd.emit_out, !o_s_tready, "emit while idle")

endmodule
`default_nettype wire
